[rtl/core/pist_pkg.sv]
// Shared constants for the point-in-simplex test: register codes and pipeline layout.
package pist_pkg;

  localparam int NUM_VTX   = 4;
  localparam int NUM_FACES = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOLID_MODE = 3'd4;

  // Item pipeline: three point stages, then difference, product, sign, result
  localparam int ST_DIFF    = 3;
  localparam int ST_PROD    = 4;
  localparam int ST_SIGN    = 5;
  localparam int ST_OUT     = 6;
  localparam int PIPE_DEPTH = ST_OUT + 1;

endpackage

[rtl/core/point_in_simplex_test_top.sv]
// Point-in-simplex test: pipelined classification of points against a triangle or tetrahedron.
//
//   channel  direction  handshake                payload
//   cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//   in       in         in_valid / in_stall      point_x, point_y, point_z
//   out      out        out_valid / out_stall    inside_res
//
// One item per cycle unless out_stall backs up the pipe; out_valid marks the result stage.
// Face normals and their orientation signs come from a five-stage pipeline on the
// vertex registers, so a write settles before any item can reach the normal stage.
// rst clears the stage valid bits and loads vertices 0 and solid mode 1.
// A stalled output holds its item; upstream stages keep filling bubbles until full.
module point_in_simplex_test_top
  import pist_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [3*COORD_WIDTH-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;      // coordinate difference
  localparam int PW = 2 * DW;      // product of two differences
  localparam int NW = PW + 1;      // normal component
  localparam int QW = NW + DW;     // normal component times difference
  localparam int SW = QW + 2;      // sum of three such products

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] norm_t;
  typedef logic signed [QW-1:0] term_t;
  typedef logic signed [SW-1:0] sum_t;

  // Configuration registers
  logic [3*CW-1:0] vtx [NUM_VTX];
  logic            solid_mode;
  coord_t          vc [NUM_VTX][3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VTX; i++) vtx[i] <= '0;
      solid_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_A:   vtx[0] <= cfg_data;
        REG_VERTEX_B:   vtx[1] <= cfg_data;
        REG_VERTEX_C:   vtx[2] <= cfg_data;
        REG_VERTEX_D:   vtx[3] <= cfg_data;
        REG_SOLID_MODE: solid_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_VTX; i++) begin
      for (int k = 0; k < 3; k++) begin
        vc[i][k] = coord_t'(vtx[i][k*CW +: CW]);
      end
    end
  end

  // Pipeline control
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] rdy;
  logic                  in_acc;

  always_comb begin
    rdy[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || !out_stall;
    for (int s = PIPE_DEPTH - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign in_stall = rst || !rdy[0];
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_acc;
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        if (rdy[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // Point delay stages: give the normal pipeline time to settle after a write
  coord_t pt [ST_DIFF][3];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pt[0][0] <= point_x;
      pt[0][1] <= point_y;
      pt[0][2] <= point_z;
    end
    for (int s = 1; s < ST_DIFF; s++) begin
      if (rdy[s]) begin
        for (int k = 0; k < 3; k++) pt[s][k] <= pt[s-1][k];
      end
    end
  end

  logic [NUM_FACES-1:0] outside;

  for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
    localparam int VB3 = (f + 1) % 4;
    localparam int VC3 = (f + 2) % 4;
    localparam int VR3 = (f + 3) % 4;
    localparam int VB2 = (f + 1) % 3;
    localparam int VR2 = (f + 2) % 3;
    localparam logic SOLID_ONLY = (f == NUM_FACES - 1);

    diff_t e1 [3];
    diff_t e2 [3];
    diff_t w1 [3];
    prod_t cp [6];
    diff_t e1d [3];
    diff_t w2 [3];
    norm_t nrm [3];
    diff_t w3 [3];
    term_t oq [3];
    sum_t  osum;
    logic  neg;

    diff_t dp [3];
    term_t tq [3];
    sum_t  tsum;
    logic  tpos;
    logic  tneg;

    // Normal pipeline, free running on the vertex registers
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= solid_mode ? DW'(vc[VB3][k]) - DW'(vc[f][k])
                            : DW'(vc[f][k]) - DW'(vc[VB2][k]);
        e2[k] <= DW'(vc[VC3][k]) - DW'(vc[f][k]);
        w1[k] <= solid_mode ? DW'(vc[f][k]) - DW'(vc[VR3][k])
                            : DW'(vc[f][k]) - DW'(vc[VR2][k]);
        e1d[k] <= e1[k];
        w2[k]  <= w1[k];
        w3[k]  <= w2[k];
        oq[k]  <= nrm[k] * w3[k];
      end
      cp[0] <= e1[1] * e2[2];
      cp[1] <= e1[2] * e2[1];
      cp[2] <= e1[2] * e2[0];
      cp[3] <= e1[0] * e2[2];
      cp[4] <= e1[0] * e2[1];
      cp[5] <= e1[1] * e2[0];
      // 2D: perpendicular of the edge, no z component
      nrm[0] <= solid_mode ? NW'(cp[0]) - NW'(cp[1]) : NW'(e1d[1]);
      nrm[1] <= solid_mode ? NW'(cp[2]) - NW'(cp[3]) : -NW'(e1d[0]);
      nrm[2] <= solid_mode ? NW'(cp[4]) - NW'(cp[5]) : NW'(0);
      neg    <= osum[SW-1];
    end

    assign osum = SW'(oq[0]) + SW'(oq[1]) + SW'(oq[2]);

    // Item stages
    always_ff @(posedge clk) begin
      if (rdy[ST_DIFF]) begin
        for (int k = 0; k < 3; k++) dp[k] <= DW'(pt[ST_DIFF-1][k]) - DW'(vc[f][k]);
      end
      if (rdy[ST_PROD]) begin
        for (int k = 0; k < 3; k++) tq[k] <= nrm[k] * dp[k];
      end
      if (rdy[ST_SIGN]) begin
        tpos <= !tsum[SW-1] && (tsum != '0);
        tneg <= tsum[SW-1];
      end
    end

    assign tsum = SW'(tq[0]) + SW'(tq[1]) + SW'(tq[2]);

    // Flip the test when the normal points inward; drop the fourth face in 2D
    assign outside[f] = (neg ? tneg : tpos) && (solid_mode || !SOLID_ONLY);
  end

  logic in_hull;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) in_hull <= !(|outside);
  end

  assign out_valid  = vld[ST_OUT];
  assign inside_res = in_hull;

endmodule

[rtl/core/pist_checker.sv]
// Port-level checker for the point-in-simplex test, bound to the top level.
module pist_assertions
  import pist_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track items in flight
  always_comb begin
    cnt_next = cnt;
    if (in_acc)  cnt_next = cnt_next + 1'b1;
    if (out_acc) cnt_next = cnt_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> cnt != '0)
    else $error("result delivered with no item in flight");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> !in_stall)
    else $error("input stalled while pipeline is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res))
    else $error("stalled result changed or dropped");

endmodule

bind point_in_simplex_test_top pist_assertions u_pist_assertions (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .inside_res (inside_res)
);

[bench/pist_checker.sv]
// Checker for the point-in-simplex test: tracks the vertex registers, predicts and compares items.
`timescale 1ns / 1ps

module pist_checker
  import pist_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [3*CW-1:0]      cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CW-1:0] point_x,
  input  logic signed [CW-1:0] point_y,
  input  logic signed [CW-1:0] point_z,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 inside_res,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int TRI_FACES = 3;

  logic [3*CW-1:0] vtx_reg [NUM_VTX];
  logic            solid_mode;
  bit              expected_inside [$];

  // z drops out entirely in triangle mode
  function automatic longint vcoord(input int idx, input int axis);
    if (axis == 2 && !solid_mode) return 0;
    return longint'($signed(vtx_reg[idx][axis*CW +: CW]));
  endfunction

  function automatic bit classify_point(input logic signed [CW-1:0] px_in,
                                        input logic signed [CW-1:0] py_in,
                                        input logic signed [CW-1:0] pz_in);
    longint px, py, pz;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, rx, ry, rz;
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    longint n0, n1, n2, orient, side;
    int     faces, f, bi, ci, ri;
    bit     inside_flag;
    faces = solid_mode ? NUM_FACES : TRI_FACES;
    px = px_in;
    py = py_in;
    pz = solid_mode ? longint'(pz_in) : 0;
    inside_flag = 1'b1;
    for (f = 0; f < faces; f++) begin
      bi = (f + 1) % faces;
      ci = (f + 2) % faces;
      ri = (f + faces - 1) % faces;
      ax = vcoord(f, 0);  ay = vcoord(f, 1);  az = vcoord(f, 2);
      bx = vcoord(bi, 0); by = vcoord(bi, 1); bz = vcoord(bi, 2);
      cx = vcoord(ci, 0); cy = vcoord(ci, 1); cz = vcoord(ci, 2);
      rx = vcoord(ri, 0); ry = vcoord(ri, 1); rz = vcoord(ri, 2);
      if (faces == TRI_FACES) begin
        // perpendicular of the edge a - b
        n0 = ay - by;
        n1 = bx - ax;
        n2 = 0;
      end else begin
        e1x = bx - ax; e1y = by - ay; e1z = bz - az;
        e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
        n0 = e1y * e2z - e1z * e2y;
        n1 = e1z * e2x - e1x * e2z;
        n2 = e1x * e2y - e1y * e2x;
      end
      // point the normal away from the vertex not on this face
      orient = n0 * (ax - rx) + n1 * (ay - ry) + n2 * (az - rz);
      if (orient < 0) begin
        n0 = -n0;
        n1 = -n1;
        n2 = -n2;
      end
      side = n0 * (px - ax) + n1 * (py - ay) + n2 * (pz - az);
      if (side > 0) inside_flag = 1'b0;
    end
    return inside_flag;
  endfunction

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      for (int i = 0; i < NUM_VTX; i++) vtx_reg[i] = '0;
      solid_mode = 1'b1;
      expected_inside.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_SOLID_MODE) vtx_reg[2'(cfg_index - REG_VERTEX_A)] = cfg_data;
        else if (cfg_index == REG_SOLID_MODE) solid_mode = cfg_data[0];
      end
      if (out_valid && !out_stall) begin
        if (expected_inside.size() == 0) begin
          $display("%0t: unexpected result, inside_res %0b", $time, inside_res);
          fail_count++;
        end else begin
          want = expected_inside.pop_front();
          if (inside_res !== want) begin
            $display("%0t: inside_res mismatch: expected %0b, got %0b", $time, want, inside_res);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_inside.push_back(classify_point(point_x, point_y, point_z));
    end
    outstanding <= expected_inside.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the point-in-simplex test: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import pist_pkg::*;

  localparam int CW   = 16;
  localparam int VW   = 3 * CW;
  localparam int CMIN = -32768;
  localparam int CMAX = 32767;

  typedef enum {SHAPE_WIDE, SHAPE_LOCAL, SHAPE_FLAT, SHAPE_CORNER} shape_t;
  typedef enum {FLOW_FREE, FLOW_HALF, FLOW_LIGHT, FLOW_HEAVY} stall_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [3*CW-1:0]      cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  logic                 out_valid;
  logic                 out_stall;
  logic                 inside_res;
  int                   fail_count;
  int                   outstanding;
  bit                   long_hold_req = 1'b0;

  logic [3*CW-1:0] vtx_set [NUM_VTX];
  int              box_lo [3];
  int              box_hi [3];

  always #1 clk = ~clk;

  point_in_simplex_test_top #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall), .inside_res(inside_res)
  );

  pist_checker #(.CW(CW)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_stall(out_stall), .inside_res(inside_res),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  function automatic logic [3*CW-1:0] pack3(input int x, input int y, input int z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic logic [3*CW-1:0] rand_word();
    return VW'({$urandom, $urandom});
  endfunction

  function automatic int coord_at(input logic [3*CW-1:0] word, input int axis);
    return int'($signed(word[axis*CW +: CW]));
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic send_point(input int x, input int y, input int z);
    in_valid <= 1'b1;
    point_x  <= x[CW-1:0];
    point_y  <= y[CW-1:0];
    point_z  <= z[CW-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all vertices and the mode, then the unused indexes with junk.
  task automatic load_config(input logic [3*CW-1:0] mode_word);
    int i;
    cfg_valid <= 1'b1;
    for (i = 0; i < (1 << CFG_IDX_W); i++) begin
      if (i < NUM_VTX) begin
        cfg_index <= CFG_IDX_W'(REG_VERTEX_A + i);
        cfg_data  <= vtx_set[i];
      end else if (i == NUM_VTX) begin
        cfg_index <= REG_SOLID_MODE;
        cfg_data  <= mode_word;
      end else begin
        cfg_index <= CFG_IDX_W'(REG_SOLID_MODE + (i - NUM_VTX));
        cfg_data  <= rand_word();
      end
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic make_vertices(input shape_t shape);
    int i, k, spread, lo, hi, margin;
    int center [3];
    int dir [3];
    for (k = 0; k < 3; k++) begin
      center[k] = rand_between(-20000, 20000);
      dir[k]    = ($urandom_range(0, 2) == 0) ? 0 : rand_between(-2000, 2000);
    end
    spread = ($urandom_range(0, 2) == 0) ? 3 : rand_between(20, 1500);
    for (i = 0; i < NUM_VTX; i++) begin
      case (shape)
        SHAPE_WIDE: vtx_set[i] = rand_word();
        SHAPE_LOCAL: vtx_set[i] = pack3(center[0] + rand_between(-spread, spread),
                                        center[1] + rand_between(-spread, spread),
                                        center[2] + rand_between(-spread, spread));
        // collinear or coincident vertices
        SHAPE_FLAT: vtx_set[i] = pack3(center[0] + i * dir[0], center[1] + i * dir[1],
                                       center[2] + i * dir[2]);
        default: begin
          for (k = 0; k < 3; k++) begin
            case ($urandom_range(0, 2))
              0: vtx_set[i][k*CW +: CW] = CW'(CMIN);
              1: vtx_set[i][k*CW +: CW] = CW'(CMAX);
              default: vtx_set[i][k*CW +: CW] = '0;
            endcase
          end
        end
      endcase
    end
    // box around the vertices with some room to spare
    for (k = 0; k < 3; k++) begin
      lo = CMAX;
      hi = CMIN;
      for (i = 0; i < NUM_VTX; i++) begin
        if (coord_at(vtx_set[i], k) < lo) lo = coord_at(vtx_set[i], k);
        if (coord_at(vtx_set[i], k) > hi) hi = coord_at(vtx_set[i], k);
      end
      margin = (hi - lo) / 4 + 4;
      box_lo[k] = clamp_coord(lo - margin);
      box_hi[k] = clamp_coord(hi + margin);
    end
  endtask

  initial begin : stimulus
    int phase, n, burst_left, gap, sel, k, vi;
    int pt [3];
    bit no_gaps;
    logic [3*CW-1:0] mode_word;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_VERTEX_A;
    cfg_data  <= '0;
    point_x   <= '0;
    point_y   <= '0;
    point_z   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset state: all vertices at the origin, so every point is inside
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMAX, CMAX);
    send_point(0, 0, 0);
    send_point(CMAX, CMIN, -1);
    wait_idle();

    vtx_set[0] = pack3(0, 0, 0);
    vtx_set[1] = pack3(1000, 0, 0);
    vtx_set[2] = pack3(0, 1000, 0);
    vtx_set[3] = pack3(0, 0, 1000);
    load_config(48'h1);
    send_point(100, 100, 100);
    send_point(0, 0, 0);
    send_point(500, 500, 0);
    send_point(-1, 0, 0);
    send_point(400, 400, 400);
    send_point(334, 333, 333);
    wait_idle();

    // full-scale tetrahedron
    vtx_set[0] = pack3(CMIN, CMIN, CMIN);
    vtx_set[1] = pack3(CMAX, CMIN, CMIN);
    vtx_set[2] = pack3(CMIN, CMAX, CMIN);
    vtx_set[3] = pack3(CMIN, CMIN, CMAX);
    load_config(48'h1);
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, CMIN, CMIN);
    send_point(0, 0, CMIN);
    wait_idle();

    // triangle with junk z everywhere and junk above the mode bit
    vtx_set[0] = pack3(-5000, -5000, CMAX);
    vtx_set[1] = pack3(5000, -5000, CMIN);
    vtx_set[2] = pack3(0, 5000, 123);
    vtx_set[3] = rand_word();
    load_config(48'hFFFF_FFFF_FFFE);
    send_point(0, 0, CMIN);
    send_point(0, 0, CMAX);
    send_point(0, 6000, 0);
    send_point(5000, -5000, 7);
    wait_idle();

    // collinear triangle: every orientation sum is zero, so no face normal is flipped
    vtx_set[0] = pack3(0, 0, 0);
    vtx_set[1] = pack3(10, 10, 0);
    vtx_set[2] = pack3(20, 20, 0);
    load_config(48'h0);
    send_point(5, 5, 0);
    send_point(6, 5, 0);
    send_point(30, 30, 0);

    for (phase = 0; phase < 12; phase++) begin
      wait_idle();
      make_vertices(phase < 2 ? SHAPE_CORNER : shape_t'($urandom_range(0, 3)));
      mode_word = rand_word();
      mode_word[0] = phase[0];
      load_config(mode_word);
      // one phase runs flat out against a long output hold to back up the pipe
      no_gaps = (phase == 3);
      if (no_gaps) long_hold_req = 1'b1;
      burst_left = 0;
      for (n = 0; n < 150; n++) begin
        if (burst_left == 0) begin
          gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        sel = $urandom_range(0, 19);
        if (sel < 3) begin
          for (k = 0; k < 3; k++) pt[k] = rand_between(CMIN, CMAX);
        end else if (sel < 5) begin
          vi = $urandom_range(0, NUM_VTX - 1);
          for (k = 0; k < 3; k++)
            pt[k] = clamp_coord(coord_at(vtx_set[vi], k) + rand_between(-1, 1));
        end else begin
          for (k = 0; k < 3; k++) pt[k] = rand_between(box_lo[k], box_hi[k]);
        end
        send_point(pt[0], pt[1], pt[2]);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin : receiver
    int seg_len, i;
    bit hold_done;
    stall_pattern_t pattern;
    hold_done = 1'b0;
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (90) @(posedge clk);
      end
      seg_len = $urandom_range(5, 60);
      pattern = stall_pattern_t'($urandom_range(0, 3));
      for (i = 0; i < seg_len; i++) begin
        case (pattern)
          FLOW_FREE:  out_stall <= 1'b0;
          FLOW_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
          FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:    out_stall <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pist_pkg.sv
rtl/core/point_in_simplex_test_top.sv
rtl/core/pist_checker.sv
bench/pist_checker.sv
bench/tb_top.sv
